// File: hw/rtl/qva_pkg.sv
package qva_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int SQRT_STAGES = 32;
	localparam int SAT_W = 64;
	localparam logic [15:0] DT_RESET = 16'd655;

	localparam logic [2:0] OP_MUL    = 3'd0;
	localparam logic [2:0] OP_CONJ   = 3'd1;
	localparam logic [2:0] OP_NORM_Q = 3'd2;
	localparam logic [2:0] OP_ROT    = 3'd3;
	localparam logic [2:0] OP_NORM_V = 3'd4;
	localparam logic [2:0] OP_RATE   = 3'd5;

	typedef struct packed {
		logic [2:0] req_type;
		logic signed [31:0] a_w;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_w;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
	} req_t;

	typedef struct packed {
		logic signed [31:0] r_w;
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic signed [31:0] r_z;
		logic zero_norm;
	} rsp_t;

	// Side information that rides along with the square root pipeline.
	typedef struct packed {
		logic zero;
		logic carry;
		logic [3:0] neg;
		logic [3:0][31:0] mag;
	} norm_tag_t;

	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic [SAT_W-32:0] hi;
		hi = v[SAT_W-1:31];
		if (hi == '0 || hi == '1) begin
			return v[31:0];
		end else if (v[SAT_W-1]) begin
			return 32'sh80000000;
		end else begin
			return 32'sh7FFFFFFF;
		end
	endfunction

endpackage

// File: hw/rtl/qva_dot_lane.sv
module qva_dot_lane #(
	parameter int FRAC_BITS = qva_pkg::FRAC_BITS_DEF,
	localparam int RW = 64 - FRAC_BITS
) (
	input  logic clk,
	input  logic en,
	input  logic signed [31:0] x [4],
	input  logic signed [31:0] y [4],
	input  logic [3:0] neg,
	output logic signed [RW-1:0] prod [4],
	output logic signed [RW+1:0] sum
);

	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

	logic signed [63:0] raw_s1 [4];
	logic signed [63:0] biased [4];
	logic signed [RW-1:0] prod_s2 [4];
	logic signed [RW+1:0] acc;
	logic signed [RW+1:0] sum_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				raw_s1[i] <= 64'(x[i]) * 64'(y[i]);
			end
		end
	end

	// Round half up: add half an LSB, then an arithmetic shift.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			biased[i] = raw_s1[i] + HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				prod_s2[i] <= $signed(biased[i][63:FRAC_BITS]);
			end
		end
	end

	// Signs are applied after rounding, as each term is rounded on its own.
	always_comb begin
		acc = '0;
		for (int i = 0; i < 4; i++) begin
			if (neg[i]) begin
				acc = acc - (RW+2)'(prod_s2[i]);
			end else begin
				acc = acc + (RW+2)'(prod_s2[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= acc;
		end
	end

	assign prod = prod_s2;
	assign sum = sum_s3;

endmodule

// File: hw/rtl/qva_isqrt.sv
module qva_isqrt (
	input  logic clk,
	input  logic en,
	input  logic [63:0] x,
	input  qva_pkg::norm_tag_t tag,
	output logic [31:0] root,
	output qva_pkg::norm_tag_t tag_out
);

	localparam int NS = qva_pkg::SQRT_STAGES;

	logic [63:0] rem_q [NS];
	logic [63:0] res_q [NS];
	qva_pkg::norm_tag_t tag_q [NS];

	logic [63:0] rem_src [NS];
	logic [63:0] res_src [NS];
	qva_pkg::norm_tag_t tag_src [NS];
	logic [63:0] rem_nx [NS];
	logic [63:0] res_nx [NS];

	// One result bit per stage, from the top pair of bits of the radicand down.
	always_comb begin
		logic [63:0] bitv;
		logic [64:0] trial;
		rem_src[0] = x;
		res_src[0] = '0;
		tag_src[0] = tag;
		for (int k = 1; k < NS; k++) begin
			rem_src[k] = rem_q[k-1];
			res_src[k] = res_q[k-1];
			tag_src[k] = tag_q[k-1];
		end
		for (int k = 0; k < NS; k++) begin
			bitv = 64'd1 << (2 * (NS - 1 - k));
			trial = {1'b0, res_src[k]} + {1'b0, bitv};
			if ({1'b0, rem_src[k]} >= trial) begin
				rem_nx[k] = rem_src[k] - trial[63:0];
				res_nx[k] = (res_src[k] >> 1) + bitv;
			end else begin
				rem_nx[k] = rem_src[k];
				res_nx[k] = res_src[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NS; k++) begin
				rem_q[k] <= rem_nx[k];
				res_q[k] <= res_nx[k];
				tag_q[k] <= tag_src[k];
			end
		end
	end

	assign root = res_q[NS-1][31:0];
	assign tag_out = tag_q[NS-1];

endmodule

// File: hw/rtl/qva_div_lane.sv
module qva_div_lane #(
	parameter int FRAC_BITS = qva_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic en,
	input  logic [31:0] mag,
	input  logic [32:0] nrm,
	output logic [FRAC_BITS:0] quo
);

	localparam int NQ = FRAC_BITS + 1;
	localparam int DW = FRAC_BITS + 34;

	logic [DW-1:0] rem_q [NQ];
	logic [NQ-1:0] quo_q [NQ];
	logic [32:0] nrm_q [NQ];

	logic [DW-1:0] rem_src [NQ];
	logic [NQ-1:0] quo_src [NQ];
	logic [32:0] nrm_src [NQ];
	logic [DW-1:0] rem_nx [NQ];
	logic [NQ-1:0] quo_nx [NQ];

	// Restoring division, one quotient bit per stage. The quotient never
	// exceeds one in fixed point, so FRAC_BITS+1 bits cover it.
	always_comb begin
		logic [DW-1:0] dv;
		logic ge;
		rem_src[0] = DW'({mag, {FRAC_BITS{1'b0}}}) + DW'(nrm >> 1);
		quo_src[0] = '0;
		nrm_src[0] = nrm;
		for (int j = 1; j < NQ; j++) begin
			rem_src[j] = rem_q[j-1];
			quo_src[j] = quo_q[j-1];
			nrm_src[j] = nrm_q[j-1];
		end
		for (int j = 0; j < NQ; j++) begin
			dv = DW'(nrm_src[j]) << (NQ - 1 - j);
			ge = rem_src[j] >= dv;
			rem_nx[j] = ge ? rem_src[j] - dv : rem_src[j];
			quo_nx[j] = {quo_src[j][NQ-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NQ; j++) begin
				rem_q[j] <= rem_nx[j];
				quo_q[j] <= quo_nx[j];
				nrm_q[j] <= nrm_src[j];
			end
		end
	end

	assign quo = quo_q[NQ-1];

endmodule

// File: hw/rtl/quaternion_vector_alu_unit.sv
// Quaternion arithmetic unit, signed fixed point with FRAC_BITS fraction bits.
// Requests arrive on req (valid/stall); each gives exactly one response on rsp
// (valid/stall). The operation is chosen by req_type: Hamilton product,
// conjugate, quaternion normalize, vector rotation, vector normalize, and the
// small-angle rate step, which uses the dt_step register.
// dt_step is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is always
// high. Write it only while no request is in flight.
// One request is taken every cycle while req_stall is low. Every operation
// runs through the same pipeline; its length is set by the 32-stage square
// root and the FRAC_BITS+1 stage dividers of the normalization lanes.
// When rsp is stalled, the response stays in the output register and one more
// finished response moves into a skid register; only then is req stalled and
// the pipeline held. Reset empties the pipeline and the output registers and
// sets dt_step to 655 (about 10 ms).
module quaternion_vector_alu_unit #(
	parameter int FRAC_BITS = qva_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic req_valid,
	output logic req_stall,
	input  qva_pkg::req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output qva_pkg::rsp_t rsp
);

	localparam int RW = 64 - FRAC_BITS;
	localparam int MW = RW + 3;
	localparam int SW = qva_pkg::SAT_W;
	localparam int DIV_FIRST = 7 + qva_pkg::SQRT_STAGES;
	localparam int LAT = DIV_FIRST + FRAC_BITS;
	localparam int EARLY_FIRST = 5;
	localparam int EARLY_ROT = 8;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
	localparam logic [3:0] NEG_A [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

	typedef logic [3:0][31:0] quad_t;

	logic en;
	logic accept;
	logic [15:0] dt_q;
	logic [LAT:1] vld_q;
	logic [2:0] op_q [1:LAT];

	logic signed [31:0] a_s1 [4], a_s2 [4], a_s3 [4], a_s4 [4];
	logic signed [31:0] b_s1 [4], b_s2 [4], b_s3 [4], b_s4 [4];

	logic signed [31:0] xa [4][4];
	logic signed [31:0] ya [4][4];
	logic signed [RW-1:0] prod_a [4][4];
	logic signed [RW+1:0] sum_a [4];

	logic signed [31:0] xb [3][4];
	logic signed [31:0] yb [3][4];
	logic signed [RW+1:0] sum_b [3];

	logic signed [32:0] rsum [3];
	logic signed [49:0] rate_s2 [3];
	logic signed [49:0] rbias [3];
	logic signed [31:0] t_s3 [3];

	logic signed [31:0] mat_d [9];
	logic signed [31:0] m_s4 [9];

	logic signed [31:0] vv [4];
	logic signed [63:0] vsq [4];
	logic [62:0] sq_s4 [4];
	logic [31:0] mag_s4 [4], mag_s5 [4];
	logic [3:0] neg_s4, neg_s5;
	logic [63:0] ps_s5 [2];
	logic [64:0] ssum;
	logic [63:0] s_s6;
	qva_pkg::norm_tag_t tag_s6;
	qva_pkg::norm_tag_t tag_s38;
	logic [31:0] root_s38;
	logic [FRAC_BITS:0] quo [4];
	logic [3:0] nneg_q [DIV_FIRST:LAT];
	logic nzero_q [DIV_FIRST:LAT];

	quad_t early_d;
	quad_t early_rot_d;
	quad_t early_q [EARLY_FIRST:LAT];

	qva_pkg::rsp_t merge_d;
	qva_pkg::rsp_t rsp_q, skid_q;
	logic rsp_valid_q, skid_valid_q;
	logic final_valid;

	assign en = !skid_valid_q;
	assign req_stall = skid_valid_q;
	assign accept = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= qva_pkg::DT_RESET;
		end else if (cfg_valid) begin
			dt_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], accept};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_q[1] <= req.req_type;
			for (int k = 2; k <= LAT; k++) begin
				op_q[k] <= op_q[k-1];
			end
			a_s1 <= '{req.a_w, req.a_x, req.a_y, req.a_z};
			b_s1 <= '{req.b_w, req.b_x, req.b_y, req.b_z};
			a_s2 <= a_s1;
			a_s3 <= a_s2;
			a_s4 <= a_s3;
			b_s2 <= b_s1;
			b_s3 <= b_s2;
			b_s4 <= b_s3;
		end
	end

	// Product lanes: one output component each for the Hamilton product, or
	// the nine quaternion cross terms that build the rotation matrix.
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			xa[l] = a_s1;
		end
		ya[0] = '{b_s1[0], b_s1[1], b_s1[2], b_s1[3]};
		ya[1] = '{b_s1[1], b_s1[0], b_s1[3], b_s1[2]};
		ya[2] = '{b_s1[2], b_s1[3], b_s1[0], b_s1[1]};
		ya[3] = '{b_s1[3], b_s1[2], b_s1[1], b_s1[0]};
		if (op_q[1] == qva_pkg::OP_ROT) begin
			xa[0] = '{a_s1[1], a_s1[2], a_s1[3], 32'sd0};
			ya[0] = '{a_s1[1], a_s1[2], a_s1[3], 32'sd0};
			xa[1] = '{a_s1[1], a_s1[1], a_s1[2], 32'sd0};
			ya[1] = '{a_s1[2], a_s1[3], a_s1[3], 32'sd0};
			xa[2] = '{a_s1[0], a_s1[0], a_s1[0], 32'sd0};
			ya[2] = '{a_s1[1], a_s1[2], a_s1[3], 32'sd0};
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane_a
		qva_dot_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk(clk),
			.en(en),
			.x(xa[l]),
			.y(ya[l]),
			.neg(NEG_A[l]),
			.prod(prod_a[l]),
			.sum(sum_a[l])
		);
	end

	// Rate step: half-angle terms (a+b)*dt/2, rounded half up.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rsum[i] = 33'(a_s1[i+1]) + 33'(b_s1[i+1]);
			rbias[i] = rate_s2[i] + 50'sd65536;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rate_s2[i] <= 50'(rsum[i]) * 50'($signed({1'b0, dt_q}));
				t_s3[i] <= qva_pkg::sat32(SW'($signed(rbias[i][49:17])));
			end
		end
	end

	// Rotation matrix from the rounded cross terms.
	always_comb begin
		logic signed [MW-1:0] bb, cc, dd, bc, bd, cd, ab, ac, ad, one_m;
		bb = MW'(prod_a[0][0]);
		cc = MW'(prod_a[0][1]);
		dd = MW'(prod_a[0][2]);
		bc = MW'(prod_a[1][0]);
		bd = MW'(prod_a[1][1]);
		cd = MW'(prod_a[1][2]);
		ab = MW'(prod_a[2][0]);
		ac = MW'(prod_a[2][1]);
		ad = MW'(prod_a[2][2]);
		one_m = MW'(ONE);
		mat_d[0] = qva_pkg::sat32(SW'(one_m - (cc <<< 1) - (dd <<< 1)));
		mat_d[1] = qva_pkg::sat32(SW'((bc - ad) <<< 1));
		mat_d[2] = qva_pkg::sat32(SW'((bd + ac) <<< 1));
		mat_d[3] = qva_pkg::sat32(SW'((bc + ad) <<< 1));
		mat_d[4] = qva_pkg::sat32(SW'(one_m - (bb <<< 1) - (dd <<< 1)));
		mat_d[5] = qva_pkg::sat32(SW'((cd - ab) <<< 1));
		mat_d[6] = qva_pkg::sat32(SW'((bd - ac) <<< 1));
		mat_d[7] = qva_pkg::sat32(SW'((cd + ab) <<< 1));
		mat_d[8] = qva_pkg::sat32(SW'(one_m - (bb <<< 1) - (cc <<< 1)));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4 <= mat_d;
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			xb[l] = '{m_s4[3*l], m_s4[3*l+1], m_s4[3*l+2], 32'sd0};
			yb[l] = '{b_s4[1], b_s4[2], b_s4[3], 32'sd0};
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane_b
		qva_dot_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk(clk),
			.en(en),
			.x(xb[l]),
			.y(yb[l]),
			.neg(4'b0000),
			.prod(),
			.sum(sum_b[l])
		);
	end

	// Results that need no normalization are formed early and wait for the
	// normalization lanes to catch up.
	always_comb begin
		early_d = '0;
		case (op_q[4])
			qva_pkg::OP_MUL: begin
				for (int i = 0; i < 4; i++) begin
					early_d[i] = qva_pkg::sat32(SW'(sum_a[i]));
				end
			end
			qva_pkg::OP_CONJ: begin
				early_d[0] = a_s4[0];
				for (int i = 1; i < 4; i++) begin
					early_d[i] = qva_pkg::sat32(-SW'(a_s4[i]));
				end
			end
			default: begin
				early_d = '0;
			end
		endcase
		early_rot_d = early_q[EARLY_ROT-1];
		if (op_q[EARLY_ROT-1] == qva_pkg::OP_ROT) begin
			early_rot_d[0] = '0;
			for (int i = 0; i < 3; i++) begin
				early_rot_d[i+1] = qva_pkg::sat32(SW'(sum_b[i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			early_q[EARLY_FIRST] <= early_d;
			for (int k = EARLY_FIRST + 1; k <= LAT; k++) begin
				if (k == EARLY_ROT) begin
					early_q[k] <= early_rot_d;
				end else begin
					early_q[k] <= early_q[k-1];
				end
			end
		end
	end

	// Normalization front end: pick the vector, square, sum.
	always_comb begin
		vv = a_s3;
		if (op_q[3] == qva_pkg::OP_RATE) begin
			vv = '{ONE, t_s3[0], t_s3[1], t_s3[2]};
		end else if (op_q[3] == qva_pkg::OP_NORM_V) begin
			vv[0] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			vsq[i] = 64'(vv[i]) * 64'(vv[i]);
		end
		ssum = 65'(ps_s5[0]) + 65'(ps_s5[1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sq_s4[i] <= vsq[i][62:0];
				mag_s4[i] <= vv[i][31] ? 32'(-33'(vv[i])) : 32'(vv[i]);
				neg_s4[i] <= vv[i][31];
			end
			ps_s5[0] <= 64'(sq_s4[0]) + 64'(sq_s4[1]);
			ps_s5[1] <= 64'(sq_s4[2]) + 64'(sq_s4[3]);
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
			s_s6 <= ssum[63:0];
			tag_s6.zero <= (ssum == '0);
			tag_s6.carry <= ssum[64];
			tag_s6.neg <= neg_s5;
			for (int i = 0; i < 4; i++) begin
				tag_s6.mag[i] <= mag_s5[i];
			end
		end
	end

	qva_isqrt u_isqrt (
		.clk(clk),
		.en(en),
		.x(s_s6),
		.tag(tag_s6),
		.root(root_s38),
		.tag_out(tag_s38)
	);

	// A sum of squares that wraps 64 bits has a root of exactly 2^32.
	for (genvar i = 0; i < 4; i++) begin : g_div
		qva_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk(clk),
			.en(en),
			.mag(tag_s38.mag[i]),
			.nrm({tag_s38.carry, root_s38}),
			.quo(quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nneg_q[DIV_FIRST] <= tag_s38.neg;
			nzero_q[DIV_FIRST] <= tag_s38.zero;
			for (int k = DIV_FIRST + 1; k <= LAT; k++) begin
				nneg_q[k] <= nneg_q[k-1];
				nzero_q[k] <= nzero_q[k-1];
			end
		end
	end

	always_comb begin
		quad_t r;
		logic zn;
		r = early_q[LAT];
		zn = 1'b0;
		if (op_q[LAT] == qva_pkg::OP_NORM_Q || op_q[LAT] == qva_pkg::OP_NORM_V
				|| op_q[LAT] == qva_pkg::OP_RATE) begin
			if (nzero_q[LAT]) begin
				r = '0;
				zn = 1'b1;
			end else begin
				for (int i = 0; i < 4; i++) begin
					if (nneg_q[LAT][i]) begin
						r[i] = qva_pkg::sat32(-SW'({1'b0, quo[i]}));
					end else begin
						r[i] = qva_pkg::sat32(SW'({1'b0, quo[i]}));
					end
				end
			end
		end
		merge_d.r_w = r[0];
		merge_d.r_x = r[1];
		merge_d.r_y = r[2];
		merge_d.r_z = r[3];
		merge_d.zero_norm = zn;
	end

	assign final_valid = vld_q[LAT] && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (rsp_valid_q && !rsp_stall) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				rsp_valid_q <= final_valid;
			end
		end else if (!rsp_valid_q) begin
			rsp_valid_q <= final_valid;
		end else if (final_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_valid_q && !rsp_stall && skid_valid_q) begin
			rsp_q <= skid_q;
		end else if (final_valid && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q <= merge_d;
		end
		if (final_valid && rsp_valid_q && rsp_stall) begin
			skid_q <= merge_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_skid_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> rsp_valid_q)
		else $error("skid register holds a response while the output register is empty");

	a_held_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall |=> rsp_valid_q)
		else $error("stalled response was dropped");

	a_zero_norm_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.zero_norm |->
		rsp_q.r_w == '0 && rsp_q.r_x == '0 && rsp_q.r_y == '0 && rsp_q.r_z == '0)
		else $error("zero length response carries nonzero components");
`endif

endmodule
